>>> rtl/vnc_pkg.sv
// ----------------------------------------------------------------------------
// vnc_pkg: shared constants for the vector length limiter
// Holds the default sample width.
// ----------------------------------------------------------------------------
package vnc_pkg;

  localparam int unsigned SampleWidthDefault = 16;

endpackage

>>> rtl/vnc_if.sv
// ----------------------------------------------------------------------------
// vnc_in_if / vnc_out_if: valid/ready channels of the vector length limiter
// One input item carries a vector and a limit; one result item carries the
// limited vector and a flag.
// ----------------------------------------------------------------------------
interface vnc_in_if #(parameter int unsigned SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] x_in;
  logic signed [SAMPLE_WIDTH-1:0] y_in;
  logic        [SAMPLE_WIDTH-2:0] length_limit;
  modport source (output valid, x_in, y_in, length_limit, input ready);
  modport sink   (input valid, x_in, y_in, length_limit, output ready);
endinterface

interface vnc_out_if #(parameter int unsigned SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] x_out;
  logic signed [SAMPLE_WIDTH-1:0] y_out;
  logic                           was_clamped;
  modport source (output valid, x_out, y_out, was_clamped, input ready);
  modport sink   (input valid, x_out, y_out, was_clamped, output ready);
endinterface

>>> rtl/vnc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vnc_sqrt_cell: one step of the restoring integer square root
// Decides one bit of the root and passes the remainder and the partial root
// to the next cell, together with the item's payload.
// ----------------------------------------------------------------------------
module vnc_sqrt_cell
  import vnc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDefault,
  parameter int unsigned STEP         = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           v_in,
  input  logic [2*SAMPLE_WIDTH-1:0]      rem_in,
  input  logic [SAMPLE_WIDTH-1:0]        root_in,
  input  logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  logic signed [SAMPLE_WIDTH-1:0] y_in,
  input  logic [SAMPLE_WIDTH-2:0]        lim_in,
  output logic                           v_out,
  output logic [2*SAMPLE_WIDTH-1:0]      rem_out,
  output logic [SAMPLE_WIDTH-1:0]        root_out,
  output logic signed [SAMPLE_WIDTH-1:0] x_out,
  output logic signed [SAMPLE_WIDTH-1:0] y_out,
  output logic [SAMPLE_WIDTH-2:0]        lim_out
);

  // The root bit decided here has weight 2^(SAMPLE_WIDTH-1-STEP).
  localparam int unsigned Sh = SAMPLE_WIDTH - 1 - STEP;
  localparam int unsigned RW = 2 * SAMPLE_WIDTH + 1;

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_ext;
  logic          take;

  // Trial value (2*root + bit) * bit with bit = 2^Sh.
  assign trial   = ({{(SAMPLE_WIDTH+1){1'b0}}, root_in} << (Sh + 1))
                 + ({{(RW-1){1'b0}}, 1'b1} << (2 * Sh));
  assign rem_ext = {1'b0, rem_in};
  assign take    = rem_ext >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out  <= take ? rem_in - trial[2*SAMPLE_WIDTH-1:0] : rem_in;
      root_out <= take ? root_in | (SAMPLE_WIDTH'(1) << Sh) : root_in;
      x_out    <= x_in;
      y_out    <= y_in;
      lim_out  <= lim_in;
    end
  end

endmodule

>>> rtl/vnc_div_cell.sv
// ----------------------------------------------------------------------------
// vnc_div_cell: one step of the restoring division of two magnitudes
// Produces one quotient bit for each of the two components, sharing the
// divisor (the norm), and passes its partial remainders along the chain.
// ----------------------------------------------------------------------------
module vnc_div_cell
  import vnc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      v_in,
  input  logic [SAMPLE_WIDTH-1:0]   norm_in,
  input  logic [2*SAMPLE_WIDTH-1:0] nx_in,
  input  logic [2*SAMPLE_WIDTH-1:0] ny_in,
  input  logic [SAMPLE_WIDTH:0]     rx_in,
  input  logic [SAMPLE_WIDTH:0]     ry_in,
  input  logic [1:0]                aux_in,
  input  logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  logic signed [SAMPLE_WIDTH-1:0] y_in,
  output logic                      v_out,
  output logic [SAMPLE_WIDTH-1:0]   norm_out,
  output logic [2*SAMPLE_WIDTH-1:0] nx_out,
  output logic [2*SAMPLE_WIDTH-1:0] ny_out,
  output logic [SAMPLE_WIDTH:0]     rx_out,
  output logic [SAMPLE_WIDTH:0]     ry_out,
  output logic [1:0]                aux_out,
  output logic signed [SAMPLE_WIDTH-1:0] x_out,
  output logic signed [SAMPLE_WIDTH-1:0] y_out
);

  // Numerators shift out MSB first; the quotient bits shift in at the bottom.
  localparam int unsigned NW = 2 * SAMPLE_WIDTH;

  logic [SAMPLE_WIDTH+1:0] sx, sy, d;
  logic                    qx, qy;

  assign d  = {2'b00, norm_in};
  assign sx = {rx_in, nx_in[NW-1]};
  assign sy = {ry_in, ny_in[NW-1]};
  assign qx = sx >= d;
  assign qy = sy >= d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_out <= norm_in;
      nx_out   <= {nx_in[NW-2:0], qx};
      ny_out   <= {ny_in[NW-2:0], qy};
      rx_out   <= qx ? (SAMPLE_WIDTH+1)'(sx - d) : sx[SAMPLE_WIDTH:0];
      ry_out   <= qy ? (SAMPLE_WIDTH+1)'(sy - d) : sy[SAMPLE_WIDTH:0];
      aux_out  <= aux_in;
      x_out    <= x_in;
      y_out    <= y_in;
    end
  end

endmodule

>>> rtl/vector_norm_clamp.sv
// ----------------------------------------------------------------------------
// vector_norm_clamp: limits the Euclidean length of a two-component vector
// Square root chain, products, division chain and output register.
// ----------------------------------------------------------------------------
// A vector (x_in, y_in) in signed Q1.15 and a limit in the same scale enter
// as one item; one result item leaves for each. The norm is the floor of the
// square root of x*x + y*y; where it exceeds the limit, each component is
// replaced by component * limit / norm truncated toward zero and the flag
// was_clamped is set, otherwise the vector passes unchanged. The block takes
// one item in every cycle while the output does not stall. From acceptance
// to result valid an item passes SAMPLE_WIDTH square root cells, two product
// stages, 2*SAMPLE_WIDTH division cells and an output stage. The whole chain
// advances together whenever the output register is empty or being emptied,
// so a stall at the output holds every stage and the input waits with it.
// ----------------------------------------------------------------------------
module vector_norm_clamp
  import vnc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDefault
) (
  input  logic     clk,
  input  logic     rst,
  vnc_in_if.sink   in_ch,
  vnc_out_if.source out_ch
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned NW = 2 * SAMPLE_WIDTH;

  logic adv;
  assign adv          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = adv;

  // ---------------- square root chain ----------------
  logic              sv   [0:W];
  logic [NW-1:0]     srem [0:W];
  logic [W-1:0]      sroot[0:W];
  logic signed [W-1:0] sx [0:W];
  logic signed [W-1:0] sy [0:W];
  logic [W-2:0]      slim [0:W];

  logic [W-1:0] ax, ay;
  logic [NW-1:0] sq_sum;
  // Magnitudes fit in W bits even for the most negative value.
  assign ax     = in_ch.x_in[W-1] ? W'(-in_ch.x_in) : W'(in_ch.x_in);
  assign ay     = in_ch.y_in[W-1] ? W'(-in_ch.y_in) : W'(in_ch.y_in);
  assign sq_sum = NW'({{W{1'b0}}, ax} * {{W{1'b0}}, ax})
                + NW'({{W{1'b0}}, ay} * {{W{1'b0}}, ay});

  assign sv[0]    = in_ch.valid;
  assign srem[0]  = sq_sum;
  assign sroot[0] = '0;
  assign sx[0]    = in_ch.x_in;
  assign sy[0]    = in_ch.y_in;
  assign slim[0]  = in_ch.length_limit;

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    vnc_sqrt_cell #(.SAMPLE_WIDTH(W), .STEP(i)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .v_in(sv[i]), .rem_in(srem[i]), .root_in(sroot[i]),
      .x_in(sx[i]), .y_in(sy[i]), .lim_in(slim[i]),
      .v_out(sv[i+1]), .rem_out(srem[i+1]), .root_out(sroot[i+1]),
      .x_out(sx[i+1]), .y_out(sy[i+1]), .lim_out(slim[i+1])
    );
  end

  // ---------------- compare and product stages ----------------
  // Stage A registers magnitudes and the clamp decision; stage B the products.
  logic              pa_v, pb_v;
  logic [W-1:0]      pa_norm, pb_norm, pa_ax, pa_ay;
  logic [W-2:0]      pa_lim;
  logic              pa_cl, pb_cl;
  logic signed [W-1:0] pa_x, pa_y, pb_x, pb_y;
  logic [NW-1:0]     pb_nx, pb_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_v <= 1'b0;
      pb_v <= 1'b0;
    end else if (adv) begin
      pa_v <= sv[W];
      pb_v <= pa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_norm <= sroot[W];
      pa_lim  <= slim[W];
      pa_cl   <= sroot[W] > {1'b0, slim[W]};
      pa_x    <= sx[W];
      pa_y    <= sy[W];
      pa_ax   <= sx[W][W-1] ? W'(-sx[W]) : W'(sx[W]);
      pa_ay   <= sy[W][W-1] ? W'(-sy[W]) : W'(sy[W]);
      pb_nx   <= NW'({{W{1'b0}}, pa_ax} * {{(W+1){1'b0}}, pa_lim});
      pb_ny   <= NW'({{W{1'b0}}, pa_ay} * {{(W+1){1'b0}}, pa_lim});
      pb_norm <= pa_norm;
      pb_cl   <= pa_cl;
      pb_x    <= pa_x;
      pb_y    <= pa_y;
    end
  end

  // ---------------- division chain ----------------
  // When no clamp happens the norm may be zero; the quotient is then unused.
  logic              dv   [0:NW];
  logic [W-1:0]      dnorm[0:NW];
  logic [NW-1:0]     dnx  [0:NW];
  logic [NW-1:0]     dny  [0:NW];
  logic [W:0]        drx  [0:NW];
  logic [W:0]        dry  [0:NW];
  logic [1:0]        daux [0:NW];
  logic signed [W-1:0] dx [0:NW];
  logic signed [W-1:0] dy [0:NW];

  assign dv[0]    = pb_v;
  assign dnorm[0] = pb_norm;
  assign dnx[0]   = pb_nx;
  assign dny[0]   = pb_ny;
  assign drx[0]   = '0;
  assign dry[0]   = '0;
  assign daux[0]  = {pb_cl, 1'b0};
  assign dx[0]    = pb_x;
  assign dy[0]    = pb_y;

  for (genvar j = 0; j < NW; j++) begin : g_div
    vnc_div_cell #(.SAMPLE_WIDTH(W)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .v_in(dv[j]), .norm_in(dnorm[j]), .nx_in(dnx[j]), .ny_in(dny[j]),
      .rx_in(drx[j]), .ry_in(dry[j]), .aux_in(daux[j]),
      .x_in(dx[j]), .y_in(dy[j]),
      .v_out(dv[j+1]), .norm_out(dnorm[j+1]), .nx_out(dnx[j+1]),
      .ny_out(dny[j+1]), .rx_out(drx[j+1]), .ry_out(dry[j+1]),
      .aux_out(daux[j+1]), .x_out(dx[j+1]), .y_out(dy[j+1])
    );
  end

  // ---------------- output register ----------------
  // After the chain the numerators have become the quotients; they never
  // exceed the limit, so the low W bits hold them.
  logic [W-1:0] qx, qy;
  logic         cl;
  assign qx = dnx[NW][W-1:0];
  assign qy = dny[NW][W-1:0];
  assign cl = daux[NW][1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= dv[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.was_clamped <= cl;
      if (cl) begin
        out_ch.x_out <= dx[NW][W-1] ? -qx : qx;
        out_ch.y_out <= dy[NW][W-1] ? -qy : qy;
      end else begin
        out_ch.x_out <= dx[NW];
        out_ch.y_out <= dy[NW];
      end
    end
  end

endmodule
